>>> rtl/rwfg_pkg.sv
`default_nettype none

package rwfg_pkg;

    localparam int MAX_LEDS     = 64;
    localparam int TIME_W       = 32;
    localparam int DELAY_W      = 16;
    localparam int COUNT_W      = 7;
    localparam int INDEX_W      = 6;
    localparam int COLOR_W      = 8;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int CMD_DEPTH    = 2;
    localparam int CMD_PTR_W    = 1;
    localparam int CMD_FILL_W   = 2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(40);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_LEDS);

    localparam logic [COLOR_W-1:0] SEG1_START = COLOR_W'(85);
    localparam logic [COLOR_W-1:0] SEG2_START = COLOR_W'(170);
    localparam logic [COLOR_W-1:0] FULL_SCALE = COLOR_W'(255);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_DELAY = 1'b0,
        REG_LED_COUNT   = 1'b1
    } cfg_reg_t;

    // one frame to be drawn by the back end
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [COLOR_W-1:0] offset;
    } frame_cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    // three-segment color wheel
    function automatic rgb_t wheel(input logic [COLOR_W-1:0] pos);
        rgb_t               c;
        logic [COLOR_W-1:0] q;
        logic [COLOR_W+1:0] t;
        begin
            if (pos < SEG1_START)
            begin
                q = pos;
            end
            else if (pos < SEG2_START)
            begin
                q = pos - SEG1_START;
            end
            else
            begin
                q = pos - SEG2_START;
            end
            t = {2'b00, q} + {1'b0, q, 1'b0};
            if (pos < SEG1_START)
            begin
                c.red   = t[COLOR_W-1:0];
                c.green = FULL_SCALE - t[COLOR_W-1:0];
                c.blue  = '0;
            end
            else if (pos < SEG2_START)
            begin
                c.red   = FULL_SCALE - t[COLOR_W-1:0];
                c.green = '0;
                c.blue  = t[COLOR_W-1:0];
            end
            else
            begin
                c.red   = '0;
                c.green = t[COLOR_W-1:0];
                c.blue  = FULL_SCALE - t[COLOR_W-1:0];
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/rwfg_time_if.sv
`default_nettype none

interface rwfg_time_if import rwfg_pkg::*;;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

`default_nettype wire

>>> rtl/rwfg_pixel_if.sv
`default_nettype none

interface rwfg_pixel_if import rwfg_pkg::*;;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] led_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               frame_end;

    modport source (output valid, output led_index, output red, output green,
                    output blue, output frame_end, input ready);
    modport sink   (input valid, input led_index, input red, input green,
                    input blue, input frame_end, output ready);
endinterface

`default_nettype wire

>>> rtl/rwfg_cfg_if.sv
`default_nettype none

interface rwfg_cfg_if import rwfg_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rainbow_wheel_frame_generator_unit.sv
// channel   role    payload                                   transaction
// time_ch   sink    now_ms[31:0]                              one time sample
// pixel_ch  source  led_index[5:0] red green blue frame_end   one led color
// cfg_ch    sink    index[0] data[15:0]                       one register write
//
// when an accepted time sample finds that the frame delay has passed, it queues a
// frame unless the led count is zero, and the back end draws one led per cycle
// while pixel_ch does not stall; frames follow each other without a gap.
// reset (rst_n, async, low) sets delay 40, led count 64, last time and hue 0.
// time_ch stalls only when the two-entry frame queue is full; a stall on pixel_ch
// holds the output register and the led sequencer, cfg_ch never stalls.
`default_nettype none

module rainbow_wheel_frame_generator_unit
    import rwfg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    rwfg_time_if.sink       time_ch,
    rwfg_pixel_if.source    pixel_ch,
    rwfg_cfg_if.sink        cfg_ch
);

    // front end to queue
    logic       cmd_push;
    frame_cmd_t push_cmd;
    logic       cmd_full;

    // queue to back end
    logic       cmd_pop;
    logic       cmd_valid;
    frame_cmd_t pop_cmd;

    // timing check, config registers and hue state
    rwfg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .time_ch  (time_ch),
        .cfg_ch   (cfg_ch),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (push_cmd)
    );

    // pending frames, lets the front keep taking time samples during a frame
    rwfg_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_cmd  (push_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .not_empty (cmd_valid),
        .pop_cmd   (pop_cmd)
    );

    // per-led sequencer, color wheel and output register
    rwfg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (pop_cmd),
        .cmd_pop   (cmd_pop),
        .pixel_ch  (pixel_ch)
    );

endmodule

`default_nettype wire

>>> rtl/rwfg_front.sv
`default_nettype none

module rwfg_front
    import rwfg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    rwfg_time_if.sink       time_ch,
    rwfg_cfg_if.sink        cfg_ch,
    input  wire logic       cmd_full,
    output logic            cmd_push,
    output frame_cmd_t      cmd
);

    logic [DELAY_W-1:0] frame_delay_reg;
    logic [COUNT_W-1:0] led_count_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic [COLOR_W-1:0] hue_offset_reg;
    logic [COLOR_W-1:0] hue_offset_next;
    logic [TIME_W-1:0]  elapsed;
    logic [COUNT_W-1:0] count_sat;
    logic               accept;
    logic               fire;

    assign cfg_ch.ready  = 1'b1;
    assign time_ch.ready = !cmd_full;
    assign accept        = time_ch.valid && time_ch.ready;

    assign elapsed   = time_ch.now_ms - last_time_reg;
    assign fire      = elapsed >= {{(TIME_W-DELAY_W){1'b0}}, frame_delay_reg};
    assign count_sat = (led_count_reg > COUNT_MAX) ? COUNT_MAX : led_count_reg;

    // 255 wraps to 1, skipping 0
    assign hue_offset_next = (hue_offset_reg == FULL_SCALE) ? COLOR_W'(1)
                                                            : hue_offset_reg + COLOR_W'(1);

    // an empty frame still advances state but queues nothing
    assign cmd_push = accept && fire && (count_sat != '0);
    assign cmd      = '{count: count_sat, offset: hue_offset_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_delay_reg <= DELAY_RESET;
            led_count_reg   <= COUNT_RESET;
            last_time_reg   <= '0;
            hue_offset_reg  <= '0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                unique case (cfg_reg_t'(cfg_ch.index))
                    REG_FRAME_DELAY: frame_delay_reg <= cfg_ch.data[DELAY_W-1:0];
                    REG_LED_COUNT:   led_count_reg   <= cfg_ch.data[COUNT_W-1:0];
                    default:         ;
                endcase
            end
            if (accept && fire)
            begin
                last_time_reg  <= time_ch.now_ms;
                hue_offset_reg <= hue_offset_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/rwfg_cmd_fifo.sv
`default_nettype none

module rwfg_cmd_fifo
    import rwfg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire frame_cmd_t push_cmd,
    output logic            full,
    input  wire logic       pop,
    output logic            not_empty,
    output frame_cmd_t      pop_cmd
);

    frame_cmd_t              entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0]    wr_ptr_reg;
    logic [CMD_PTR_W-1:0]    rd_ptr_reg;
    logic [CMD_FILL_W-1:0]   fill_reg;

    assign full      = fill_reg == CMD_FILL_W'(CMD_DEPTH);
    assign not_empty = fill_reg != '0;
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMD_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMD_PTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + CMD_FILL_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - CMD_FILL_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/rwfg_back.sv
`default_nettype none

module rwfg_back
    import rwfg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  wire frame_cmd_t cmd,
    output logic            cmd_pop,
    rwfg_pixel_if.source    pixel_ch
);

    logic               busy_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COLOR_W-1:0] offset_reg;

    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    rgb_t               out_rgb_reg;
    logic               out_end_reg;

    logic               can_load;
    logic               advance;
    logic               last;
    logic [COLOR_W-1:0] pos;
    rgb_t               color;

    assign can_load = !out_valid_reg || pixel_ch.ready;
    assign advance  = busy_reg && can_load;
    assign last     = ({1'b0, idx_reg} + COUNT_W'(1)) == count_reg;
    assign cmd_pop  = cmd_valid && (!busy_reg || (advance && last));

    assign pos   = {{(COLOR_W-INDEX_W){1'b0}}, idx_reg} + offset_reg;
    assign color = wheel(pos);

    assign pixel_ch.valid     = out_valid_reg;
    assign pixel_ch.led_index = out_index_reg;
    assign pixel_ch.red       = out_rgb_reg.red;
    assign pixel_ch.green     = out_rgb_reg.green;
    assign pixel_ch.blue      = out_rgb_reg.blue;
    assign pixel_ch.frame_end = out_end_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            count_reg  <= cmd.count;
            offset_reg <= cmd.offset;
        end
        if (advance)
        begin
            out_index_reg <= idx_reg;
            out_rgb_reg   <= color;
            out_end_reg   <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (advance)
            begin
                busy_reg <= !last;
                idx_reg  <= idx_reg + INDEX_W'(1);
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_rainbow_wheel_frame_generator_unit.sv
`default_nettype none

module tb_rainbow_wheel_frame_generator_unit;
    import rwfg_pkg::*;

    // watchdog: cycles with no transaction on any channel before giving up
    localparam int WATCHDOG_LIMIT = 3000;
    // long receiver hold-off, long enough to fill the frame queue
    localparam int HOLD_CYCLES    = 400;
    // extra cycles after the last color so empty frames can retire
    localparam int SETTLE_CYCLES  = 16;

    typedef enum logic {
        ROW_WRITE,
        ROW_TIME
    } row_kind_t;

    // one directed step: a register write or a time sample with an optional
    // hand-computed outcome (number of colors and color of led 0)
    typedef struct packed {
        row_kind_t          kind;
        cfg_reg_t           reg_sel;
        logic [TIME_W-1:0]  value;
        logic               typed;
        logic [6:0]         n_leds;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } row_t;

    // one expected led color
    typedef struct packed {
        logic [INDEX_W-1:0] led;
        rgb_t               color;
        logic               last;
    } led_px_t;

    localparam int N_ROWS = 20;
    localparam row_t DIRECTED [0:N_ROWS-1] = '{
        // after reset: delay 40, 64 leds, last time 0, hue 0
        '{ROW_TIME,  REG_FRAME_DELAY, 32'd0,          1'b1, 7'd0,  8'd0,  8'd0,   8'd0},
        '{ROW_TIME,  REG_FRAME_DELAY, 32'd39,         1'b1, 7'd0,  8'd0,  8'd0,   8'd0},
        '{ROW_TIME,  REG_FRAME_DELAY, 32'd40,         1'b1, 7'd64, 8'd0,  8'd255, 8'd0},
        '{ROW_TIME,  REG_FRAME_DELAY, 32'd79,         1'b1, 7'd0,  8'd0,  8'd0,   8'd0},
        '{ROW_TIME,  REG_FRAME_DELAY, 32'd80,         1'b1, 7'd64, 8'd3,  8'd252, 8'd0},
        // empty frame still moves time and hue
        '{ROW_WRITE, REG_LED_COUNT,   32'd0,          1'b0, 7'd0,  8'd0,  8'd0,   8'd0},
        '{ROW_TIME,  REG_FRAME_DELAY, 32'd200,        1'b1, 7'd0,  8'd0,  8'd0,   8'd0},
        // zero delay fires on every sample, even a repeated time
        '{ROW_WRITE, REG_LED_COUNT,   32'd1,          1'b0, 7'd0,  8'd0,  8'd0,   8'd0},
        '{ROW_WRITE, REG_FRAME_DELAY, 32'd0,          1'b0, 7'd0,  8'd0,  8'd0,   8'd0},
        '{ROW_TIME,  REG_FRAME_DELAY, 32'd200,        1'b1, 7'd1,  8'd9,  8'd246, 8'd0},
        '{ROW_TIME,  REG_FRAME_DELAY, 32'hFFFF_FFFF,  1'b1, 7'd1,  8'd12, 8'd243, 8'd0},
        // oversized count saturates, max delay across the time wrap
        '{ROW_WRITE, REG_LED_COUNT,   32'd127,        1'b0, 7'd0,  8'd0,  8'd0,   8'd0},
        '{ROW_WRITE, REG_FRAME_DELAY, 32'd65535,      1'b0, 7'd0,  8'd0,  8'd0,   8'd0},
        '{ROW_TIME,  REG_FRAME_DELAY, 32'd65533,      1'b1, 7'd0,  8'd0,  8'd0,   8'd0},
        '{ROW_TIME,  REG_FRAME_DELAY, 32'd65534,      1'b1, 7'd64, 8'd15, 8'd240, 8'd0},
        '{ROW_TIME,  REG_FRAME_DELAY, 32'd0,          1'b1, 7'd64, 8'd18, 8'd237, 8'd0},
        // just above the led limit, minimum nonzero delay
        '{ROW_WRITE, REG_LED_COUNT,   32'd65,         1'b0, 7'd0,  8'd0,  8'd0,   8'd0},
        '{ROW_WRITE, REG_FRAME_DELAY, 32'd1,          1'b0, 7'd0,  8'd0,  8'd0,   8'd0},
        '{ROW_TIME,  REG_FRAME_DELAY, 32'd1,          1'b1, 7'd64, 8'd21, 8'd234, 8'd0},
        '{ROW_TIME,  REG_FRAME_DELAY, 32'd1,          1'b1, 7'd0,  8'd0,  8'd0,   8'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    rwfg_time_if  time_bus ();
    rwfg_pixel_if pixel_bus ();
    rwfg_cfg_if   cfg_bus ();

    rainbow_wheel_frame_generator_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .time_ch  (time_bus),
        .pixel_ch (pixel_bus),
        .cfg_ch   (cfg_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state: a private copy of the registers and frame timing
    logic [DELAY_W-1:0] delay_ms;
    logic [COUNT_W-1:0] led_cfg;
    logic [TIME_W-1:0]  last_fire_ms;
    logic [COLOR_W-1:0] hue;

    led_px_t expected_leds [$];

    int mismatches     = 0;
    int idle_cycles    = 0;
    int samples_sent   = 0;
    int frames_fired   = 0;
    int frames_empty   = 0;
    int frames_skipped = 0;
    int leds_checked   = 0;
    int reg_writes     = 0;
    int hue_wraps      = 0;

    // led 0 color seen most recently, for the hand-computed rows
    rgb_t led0_seen;

    // long hold-off handshake between sender and receiver processes
    int holds_asked  = 0;
    int holds_served = 0;

    logic [TIME_W-1:0] clock_ms;

    task automatic flag_mismatch(input string detail);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch at %0t: %s", $time, detail);
        end
    endtask

    // three-segment wheel: green->red fade, then red->blue, then blue->green
    function automatic rgb_t hue_to_rgb(input logic [COLOR_W-1:0] pos);
        rgb_t        c;
        int unsigned q;
        if (pos < 8'd85)
        begin
            q       = 3 * pos;
            c.red   = 8'(q);
            c.green = 8'(255 - q);
            c.blue  = 8'd0;
        end
        else if (pos < 8'd170)
        begin
            q       = 3 * (pos - 8'd85);
            c.red   = 8'(255 - q);
            c.green = 8'd0;
            c.blue  = 8'(q);
        end
        else
        begin
            q       = 3 * (pos - 8'd170);
            c.red   = 8'd0;
            c.green = 8'(q);
            c.blue  = 8'(255 - q);
        end
        return c;
    endfunction

    // decide whether a time sample fires and queue the colors it draws
    task automatic predict_frame(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        int                n;
        led_px_t           px;
        elapsed = now - last_fire_ms;
        if (elapsed < {16'd0, delay_ms})
        begin
            frames_skipped++;
            return;
        end
        n = (led_cfg > COUNT_W'(MAX_LEDS)) ? MAX_LEDS : int'(led_cfg);
        for (int i = 0; i < n; i++)
        begin
            px.led   = INDEX_W'(i);
            px.color = hue_to_rgb(COLOR_W'(i) + hue);
            px.last  = (i == n - 1);
            expected_leds.insert(expected_leds.size(), px);
        end
        last_fire_ms = now;
        // hue skips zero when it wraps
        if (hue == 8'd255)
        begin
            hue = 8'd1;
            hue_wraps++;
        end
        else
        begin
            hue = hue + 8'd1;
        end
        frames_fired++;
        if (n == 0)
        begin
            frames_empty++;
        end
    endtask

    task automatic check_led(input led_px_t got);
        led_px_t want;
        if (expected_leds.size() == 0)
        begin
            flag_mismatch($sformatf("led color with nothing expected, index %0d", got.led));
            return;
        end
        want = expected_leds.pop_front();
        leds_checked++;
        if (got.led != want.led)
        begin
            flag_mismatch($sformatf("led_index expected %0d got %0d", want.led, got.led));
        end
        if (got.color.red != want.color.red)
        begin
            flag_mismatch($sformatf("red of led %0d expected %0d got %0d",
                                    want.led, want.color.red, got.color.red));
        end
        if (got.color.green != want.color.green)
        begin
            flag_mismatch($sformatf("green of led %0d expected %0d got %0d",
                                    want.led, want.color.green, got.color.green));
        end
        if (got.color.blue != want.color.blue)
        begin
            flag_mismatch($sformatf("blue of led %0d expected %0d got %0d",
                                    want.led, want.color.blue, got.color.blue));
        end
        if (got.last != want.last)
        begin
            flag_mismatch($sformatf("frame_end of led %0d expected %0d got %0d",
                                    want.led, want.last, got.last));
        end
    endtask

    // monitor: every transaction is sampled at the clock edge that accepts it
    always @(posedge clk)
    begin
        led_px_t got;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                reg_writes++;
                if (cfg_bus.index == REG_FRAME_DELAY)
                begin
                    delay_ms = cfg_bus.data;
                end
                else
                begin
                    led_cfg = cfg_bus.data[COUNT_W-1:0];
                end
            end
            if (time_bus.valid && time_bus.ready)
            begin
                predict_frame(time_bus.now_ms);
            end
            if (pixel_bus.valid && pixel_bus.ready)
            begin
                got.led         = pixel_bus.led_index;
                got.color.red   = pixel_bus.red;
                got.color.green = pixel_bus.green;
                got.color.blue  = pixel_bus.blue;
                got.last        = pixel_bus.frame_end;
                if (got.led == '0)
                begin
                    led0_seen = got.color;
                end
                check_led(got);
            end
            if ((cfg_bus.valid && cfg_bus.ready) || (time_bus.valid && time_bus.ready)
                || (pixel_bus.valid && pixel_bus.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
    end

    // watchdog
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // receiver: switches between stall patterns, plus long hold-offs on request
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        pixel_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                pixel_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (holds_served != holds_asked)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES - 1;
                pixel_bus.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       pixel_bus.ready <= 1'b1;
                    1:       pixel_bus.ready <= mode_left[0];
                    2:       pixel_bus.ready <= ($urandom_range(0, 3) != 0);
                    default: pixel_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // offer one time sample and hold it until accepted
    task automatic send_time(input logic [TIME_W-1:0] now);
        time_bus.valid  <= 1'b1;
        time_bus.now_ms <= now;
        do
        begin
            @(posedge clk);
        end
        while (!(time_bus.valid && time_bus.ready));
        samples_sent++;
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= sel;
        cfg_bus.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!(cfg_bus.valid && cfg_bus.ready));
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // sender pause: wait for every queued color, then let empty frames retire
    task automatic wait_frames_drained();
        time_bus.valid <= 1'b0;
        // let the monitor predict the last accepted sample before the queue is checked
        @(posedge clk);
        while (expected_leds.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one random phase: mostly a time cursor that steps around the delay,
    // with near misses and jumps to arbitrary times as noise
    task automatic run_phase(input logic [DELAY_W-1:0] delay, input logic [CFG_DATA_W-1:0] leds,
                             input int n_items, input bit squeeze);
        int          left;
        int          burst;
        int          gap;
        int          pick;
        logic [31:0] step;
        write_reg(REG_FRAME_DELAY, delay);
        write_reg(REG_LED_COUNT, leds);
        // receiver freezes while the sender keeps offering back to back
        if (squeeze)
        begin
            holds_asked++;
        end
        left = n_items;
        while (left > 0)
        begin
            burst = squeeze ? left : $urandom_range(1, 16);
            if (burst > left)
            begin
                burst = left;
            end
            repeat (burst)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    step     = {16'd0, delay} + $urandom_range(0, delay / 2 + 3);
                    clock_ms = clock_ms + step;
                end
                else if (pick < 85)
                begin
                    if (delay == 0)
                    begin
                        step = 0;
                    end
                    else if ($urandom_range(0, 1) == 1)
                    begin
                        step = {16'd0, delay} - 1;
                    end
                    else
                    begin
                        step = $urandom_range(0, delay - 1);
                    end
                    clock_ms = clock_ms + step;
                end
                else
                begin
                    clock_ms = $urandom;
                end
                send_time(clock_ms);
            end
            left -= burst;
            gap = $urandom_range(0, 8);
            if (gap > 0 && left > 0)
            begin
                time_bus.valid  <= 1'b0;
                time_bus.now_ms <= $urandom;
                repeat (gap) @(posedge clk);
            end
        end
        wait_frames_drained();
    endtask

    initial
    begin
        int n_before;
        delay_ms     = 16'd40;
        led_cfg      = 7'd64;
        last_fire_ms = '0;
        hue          = '0;
        led0_seen    = '0;
        clock_ms     = '0;

        rst_n           = 1'b0;
        time_bus.valid  = 1'b0;
        time_bus.now_ms = '0;
        cfg_bus.valid   = 1'b0;
        cfg_bus.index   = REG_FRAME_DELAY;
        cfg_bus.data    = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: each row runs alone so its outcome can be checked
        for (int r = 0; r < N_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_WRITE)
            begin
                write_reg(DIRECTED[r].reg_sel, DIRECTED[r].value[CFG_DATA_W-1:0]);
            end
            else
            begin
                n_before = leds_checked;
                send_time(DIRECTED[r].value);
                wait_frames_drained();
                if (DIRECTED[r].typed)
                begin
                    if (leds_checked - n_before != int'(DIRECTED[r].n_leds))
                    begin
                        flag_mismatch($sformatf("row %0d color count expected %0d got %0d",
                                                r, DIRECTED[r].n_leds, leds_checked - n_before));
                    end
                    if (DIRECTED[r].n_leds != 0 && led0_seen != {DIRECTED[r].red,
                        DIRECTED[r].green, DIRECTED[r].blue})
                    begin
                        flag_mismatch($sformatf("row %0d led 0 expected %h got %h", r,
                                                {DIRECTED[r].red, DIRECTED[r].green,
                                                 DIRECTED[r].blue}, led0_seen));
                    end
                end
            end
        end
        clock_ms = 32'd1;

        // random part: zero delay and empty frames race the hue around its wrap
        run_phase(16'd0, 16'd0, 130, 1'b0);
        run_phase(16'd1, 16'd1, 40, 1'b0);
        run_phase(16'd0, 16'd3, 40, 1'b0);
        // led count with junk in the unused upper data bits
        run_phase(16'($urandom_range(2, 100)),
                  16'($urandom_range(1, 64) | ($urandom_range(0, 511) << 7)), 40, 1'b0);
        run_phase(16'd65535, 16'd127, 25, 1'b0);
        run_phase(16'd40, 16'd64, 25, 1'b1);

        wait_frames_drained();
        while (expected_leds.size() != 0)
        begin
            void'(expected_leds.pop_front());
            flag_mismatch("expected led color never arrived");
        end

        $display("covered %0d time samples: %0d frames drawn (%0d empty), %0d held back",
                 samples_sent, frames_fired, frames_empty, frames_skipped);
        $display("checked %0d led colors over %0d register writes, hue wrapped %0d times",
                 leds_checked, reg_writes, hue_wraps);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
